// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the RTL of the authority manager.
// No dependencies; the including module must provide clk and rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is held
`define DCAM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds through reset
`define DCAM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/dcam_pkg.sv -----
// Types and constants for the dual-channel authority manager.
// No dependencies; used by dual_channel_authority_manager.
package dcam_pkg;

  // Channel role codes
  typedef enum logic [1:0] {
    ROLE_ACTIVE  = 2'd0,
    ROLE_STANDBY = 2'd1,
    ROLE_FAILED  = 2'd2
  } role_t;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 24;
  localparam logic [CFG_IDX_W-1:0] CFG_NODE_ID          = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEALTH_THRESHOLD = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LINK_TIMEOUT_US  = 2'd2;

  // Register reset values
  localparam logic [6:0]  HEALTH_THRESHOLD_RST = 7'd50;
  localparam logic [23:0] LINK_TIMEOUT_RST     = 24'd100000;

  // One control tick
  typedef struct packed {
    logic [15:0] local_fault_word;
    logic [15:0] remote_fault_word;
    logic [31:0] local_cfg_sum;
    logic [31:0] remote_cfg_sum;
    logic [7:0]  remote_mode;
    logic        partner_alive;
    logic        partner_data_valid;
    logic [15:0] elapsed_us;
  } in_item_t;

  // One authority result
  typedef struct packed {
    logic        authority;
    logic [1:0]  role;
    logic [6:0]  health;
    logic        partner_lost;
  } out_item_t;

endpackage

// ----- rtl/dual_channel_authority_manager.sv -----
// Dual-channel authority manager: role, health and partner-loss tracking.
// Depends on dcam_pkg and assert_macros.svh.
//
// Takes one control tick per clock while in_stall is low and returns one result
// per tick: the tick lands in an input register, the role, health and silence
// logic works on it in a single pass, and the answer sits in a result register
// that drives out_data. The role and silence registers update as the tick
// moves into the result register, so a result register stalled downstream
// only holds the input register and never loses state. Role resets to active
// (node_id resets to 0); later node_id writes affect only conflict
// resolution. Failed is final until reset.
`include "assert_macros.svh"

module dual_channel_authority_manager (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // tick channel
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  dcam_pkg::in_item_t                    in_data,
  // result channel
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output dcam_pkg::out_item_t                   out_data,
  // configuration
  input  logic                                  cfg_we,
  input  logic [dcam_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [dcam_pkg::CFG_DATA_W-1:0]       cfg_wdata
);

  localparam logic [6:0]  SCORE_FULL   = 7'd100;
  localparam logic [6:0]  SENSOR_LOSS  = 7'd25;
  localparam logic [6:0]  SYSTEM_LOSS  = 7'd40;
  localparam logic [23:0] SILENCE_MAX  = 24'hFFFFFF;

  // Health score from a fault word
  function automatic logic [6:0] score_of(input logic [15:0] word);
    logic [6:0] s;
    s = SCORE_FULL;
    if (word[7:0] != 8'd0) begin
      s = s - SENSOR_LOSS;
    end
    if (word[15:8] != 8'd0) begin
      s = s - SYSTEM_LOSS;
    end
    return s;
  endfunction

  // Configuration registers
  logic        node_id_r;
  logic [6:0]  health_thr_r;
  logic [23:0] link_timeout_r;

  // Channel state
  dcam_pkg::role_t role_r, role_nxt;
  logic [23:0]     silence_r, silence_nxt;
  logic            lost_r, lost_nxt;
  logic [6:0]      health_nxt;

  // Pipeline registers
  logic                s1_valid_r, s1_valid_nxt;
  dcam_pkg::in_item_t  s1_data_r;
  logic                out_valid_r, out_valid_nxt;
  dcam_pkg::out_item_t out_data_r, out_data_nxt;

  logic s1_adv;
  logic in_acc;

  // Handshake
  assign s1_adv   = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !s1_adv;
  assign in_acc   = in_valid && !in_stall;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Write configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_id_r      <= 1'b0;
      health_thr_r   <= dcam_pkg::HEALTH_THRESHOLD_RST;
      link_timeout_r <= dcam_pkg::LINK_TIMEOUT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        dcam_pkg::CFG_NODE_ID:          node_id_r      <= cfg_wdata[0];
        dcam_pkg::CFG_HEALTH_THRESHOLD: health_thr_r   <= cfg_wdata[6:0];
        dcam_pkg::CFG_LINK_TIMEOUT_US:  link_timeout_r <= cfg_wdata[23:0];
        default: ;
      endcase
    end
  end

  // Decide role, health and link state for the tick in the input register
  always_comb begin
    logic [6:0]  rhealth;
    logic [24:0] sil_sum;
    logic [23:0] sil_sat;

    health_nxt  = score_of(s1_data_r.local_fault_word);
    rhealth     = score_of(s1_data_r.remote_fault_word);
    role_nxt    = role_r;
    silence_nxt = silence_r;
    lost_nxt    = lost_r;
    sil_sum     = {1'b0, silence_r} + {9'd0, s1_data_r.elapsed_us};
    sil_sat     = sil_sum[24] ? SILENCE_MAX : sil_sum[23:0];

    if (health_nxt == 7'd0) begin
      role_nxt = dcam_pkg::ROLE_FAILED;
    end

    if (s1_data_r.partner_alive) begin
      // heartbeat: clear the silence timer
      silence_nxt = '0;
      lost_nxt    = 1'b0;
      if (s1_data_r.partner_data_valid) begin
        if (s1_data_r.local_cfg_sum != s1_data_r.remote_cfg_sum) begin
          health_nxt = 7'd0;
          role_nxt   = dcam_pkg::ROLE_FAILED;
        end
        unique case (role_nxt)
          dcam_pkg::ROLE_ACTIVE: begin
            // yield on split brain, or hand over when degraded
            if ((s1_data_r.remote_mode == 8'd0) && node_id_r) begin
              role_nxt = dcam_pkg::ROLE_STANDBY;
            end
            if ((health_nxt < health_thr_r) && (rhealth > health_nxt)) begin
              role_nxt = dcam_pkg::ROLE_STANDBY;
            end
          end
          dcam_pkg::ROLE_STANDBY: begin
            // take over from a degraded partner
            if ((rhealth < health_thr_r) && (health_nxt >= health_thr_r)) begin
              role_nxt = dcam_pkg::ROLE_ACTIVE;
            end
          end
          default: ;
        endcase
      end
    end else begin
      // silence: accumulate and check the timeout
      silence_nxt = sil_sat;
      if (sil_sat >= link_timeout_r) begin
        lost_nxt = 1'b1;
        if ((role_r == dcam_pkg::ROLE_STANDBY) && (health_nxt >= health_thr_r)) begin
          role_nxt = dcam_pkg::ROLE_ACTIVE;
        end
      end
    end

    out_data_nxt.authority    = (role_nxt == dcam_pkg::ROLE_ACTIVE);
    out_data_nxt.role         = role_nxt;
    out_data_nxt.health       = health_nxt;
    out_data_nxt.partner_lost = lost_nxt;
  end

  // Valid flags
  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_acc) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (s1_adv) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control and channel state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      role_r      <= dcam_pkg::ROLE_ACTIVE;
      silence_r   <= '0;
      lost_r      <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (s1_adv) begin
        role_r    <= role_nxt;
        silence_r <= silence_nxt;
        lost_r    <= lost_nxt;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_data_r <= in_data;
    end
    if (s1_adv) begin
      out_data_r <= out_data_nxt;
    end
  end

  // Checks
  `DCAM_ASSERT(a_failed_sticky, (role_r == dcam_pkg::ROLE_FAILED) |=> (role_r == dcam_pkg::ROLE_FAILED), "failed role left without reset")
  `DCAM_ASSERT(a_adv_gives_result, s1_adv |=> out_valid_r, "advanced item missing from result register")
  `DCAM_ASSERT(a_auth_matches_role, out_valid_r |-> (out_data_r.authority == (out_data_r.role == dcam_pkg::ROLE_ACTIVE)), "authority disagrees with role")
  `DCAM_ASSERT(a_health_legal, out_valid_r |-> (out_data_r.health == 7'd0 || out_data_r.health == 7'd35 || out_data_r.health == 7'd60 || out_data_r.health == 7'd75 || out_data_r.health == 7'd100), "illegal health score")
  `DCAM_ASSERT_ALWAYS(a_stall_needs_item, in_stall |-> s1_valid_r, "stall with empty input register")

endmodule
